// File: rtl/pfc_pkg.sv
package pfc_pkg;

  localparam int unsigned SIDE  = 5;
  localparam int unsigned CELLS = 25;

  typedef logic [4:0] letter_t;

  localparam letter_t CODE_I = 5'd8;
  localparam letter_t CODE_J = 5'd9;
  localparam letter_t CODE_Q = 5'd16;
  localparam letter_t CODE_X = 5'd23;
  localparam letter_t CODE_Z = 5'd25;

  // Shift amounts for the mod-5 moves inside the square.
  localparam logic [2:0] SHIFT_ENC = 3'd1;
  localparam logic [2:0] SHIFT_DEC = 3'd4;

  typedef enum logic [1:0] {
    REG_DECRYPT_MODE = 2'd0,
    REG_SQUARE_A     = 2'd1,
    REG_SQUARE_B     = 2'd2,
    REG_SQUARE_C     = 2'd3
  } cfg_reg_t;

  localparam int unsigned CFG_DATA_W = 45;

  // Cell k of the key square sits in element k.
  typedef logic [CELLS-1:0][4:0] square_t;

  typedef logic [CELLS-1:0] match_t;

  typedef struct packed {
    letter_t a;
    letter_t b;
    logic    last;
  } digraph_t;

  // Queue head toward the cipher stage.
  typedef struct packed {
    logic     valid;
    digraph_t pair;
  } head_t;

endpackage

// File: rtl/pfc_letter_if.sv
interface pfc_letter_if;
  logic       valid;
  logic       ready;
  logic [4:0] letter_in;
  logic       end_of_message;

  modport source(output valid, letter_in, end_of_message, input ready);
  modport sink(input valid, letter_in, end_of_message, output ready);
endinterface

// File: rtl/pfc_digraph_if.sv
interface pfc_digraph_if;
  logic       valid;
  logic       ready;
  logic [4:0] first_out;
  logic [4:0] second_out;
  logic       final_pair;

  modport source(output valid, first_out, second_out, final_pair, input ready);
  modport sink(input valid, first_out, second_out, final_pair, output ready);
endinterface

// File: rtl/playfair_digraph_cipher.sv
// Streaming Playfair cipher. Takes one letter word per cycle while the queue
// has room, returns one enciphered digraph word per cycle while the sink is
// ready; a digraph goes from the queue via a match register to the output
// register. A doubled letter ending a message makes two words from one, so a
// four-entry queue sits between pairing and enciphering; letters are taken
// only with room for two. Load the key square and mode while the block is idle.
module playfair_digraph_cipher (
  input  logic                                clk,
  input  logic                                rst,
  pfc_letter_if.sink                          letters,
  pfc_digraph_if.source                       digraphs,
  input  logic                                cfg_wr_en,
  input  logic [1:0]                          cfg_index,
  input  logic [pfc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  logic            decrypt_mode;
  logic [44:0]     square_part_a;
  logic [39:0]     square_part_b;
  logic [39:0]     square_part_c;
  pfc_pkg::square_t square;
  pfc_pkg::head_t  head;
  logic            pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      decrypt_mode  <= 1'b0;
      square_part_a <= '0;
      square_part_b <= '0;
      square_part_c <= '0;
    end else if (cfg_wr_en) begin
      unique case (pfc_pkg::cfg_reg_t'(cfg_index))
        pfc_pkg::REG_DECRYPT_MODE: decrypt_mode  <= cfg_data[0];
        pfc_pkg::REG_SQUARE_A:     square_part_a <= cfg_data[44:0];
        pfc_pkg::REG_SQUARE_B:     square_part_b <= cfg_data[39:0];
        pfc_pkg::REG_SQUARE_C:     square_part_c <= cfg_data[39:0];
        default: ;
      endcase
    end
  end

  assign square = {square_part_c, square_part_b, square_part_a};

  pfc_pair u_pair (
    .clk     (clk),
    .rst     (rst),
    .letters (letters),
    .head    (head),
    .pop     (pop)
  );

  pfc_cipher u_cipher (
    .clk          (clk),
    .rst          (rst),
    .decrypt_mode (decrypt_mode),
    .square       (square),
    .head         (head),
    .pop          (pop),
    .digraphs     (digraphs)
  );

endmodule

// File: rtl/pfc_pair.sv
module pfc_pair (
  input  logic                clk,
  input  logic                rst,
  pfc_letter_if.sink          letters,
  output pfc_pkg::head_t      head,
  input  logic                pop
);

  localparam int unsigned DEPTH = 4;

  logic                 held_valid;
  pfc_pkg::letter_t     held_letter;
  pfc_pkg::digraph_t    queue [DEPTH];
  logic [1:0]           wr_ptr;
  logic [1:0]           rd_ptr;
  logic [2:0]           count;

  pfc_pkg::letter_t     c;
  logic                 take;
  logic                 push0;
  logic                 push1;
  pfc_pkg::digraph_t    pair0;
  pfc_pkg::digraph_t    pair1;
  logic                 held_valid_next;
  logic [1:0]           npush;

  // Room for two pairs keeps a doubled letter at message end from overflowing.
  assign letters.ready = (count <= 3'd2);
  assign take          = letters.valid && letters.ready;

  always_comb begin
    c = (letters.letter_in == pfc_pkg::CODE_J) ? pfc_pkg::CODE_I : letters.letter_in;
    push0           = 1'b0;
    push1           = 1'b0;
    pair0           = '{a: held_letter, b: c, last: letters.end_of_message};
    pair1           = pair0;
    held_valid_next = held_valid;
    if (take) begin
      if (held_valid && held_letter != c) begin
        push0           = 1'b1;
        held_valid_next = 1'b0;
      end else begin
        if (held_valid) begin
          // Doubled letter: fill with X, or Q after an X.
          pair0 = '{a: held_letter,
                    b: (c == pfc_pkg::CODE_X) ? pfc_pkg::CODE_Q : pfc_pkg::CODE_X,
                    last: 1'b0};
        end
        if (letters.end_of_message) begin
          // Pad the lone letter with Z, or X after a Z.
          pair1 = '{a: c,
                    b: (c == pfc_pkg::CODE_Z) ? pfc_pkg::CODE_X : pfc_pkg::CODE_Z,
                    last: 1'b1};
          held_valid_next = 1'b0;
        end else begin
          held_valid_next = 1'b1;
        end
        if (held_valid) begin
          push0 = 1'b1;
          push1 = letters.end_of_message;
        end else if (letters.end_of_message) begin
          push0 = 1'b1;
          pair0 = pair1;
        end
      end
    end
    npush = {1'b0, push0} + {1'b0, push1};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      count      <= '0;
    end else begin
      held_valid <= held_valid_next;
      wr_ptr     <= wr_ptr + npush;
      rd_ptr     <= rd_ptr + {1'b0, pop};
      count      <= count + {1'b0, npush} - {2'b00, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (take && !(held_valid && held_letter != c)) begin
      held_letter <= c;
    end
    if (push0) begin
      queue[wr_ptr] <= pair0;
    end
    if (push1) begin
      queue[wr_ptr + 2'd1] <= pair1;
    end
  end

  assign head.valid = (count != 3'd0);
  assign head.pair  = queue[rd_ptr];

endmodule

// File: rtl/pfc_cipher.sv
module pfc_cipher (
  input  logic                clk,
  input  logic                rst,
  input  logic                decrypt_mode,
  input  pfc_pkg::square_t    square,
  input  pfc_pkg::head_t      head,
  output logic                pop,
  pfc_digraph_if.source       digraphs
);

  logic              s1_valid;
  pfc_pkg::match_t   s1_match_a;
  pfc_pkg::match_t   s1_match_b;
  logic              s1_last;

  logic              out_free;
  logic              s1_load;
  pfc_pkg::match_t   match_a;
  pfc_pkg::match_t   match_b;

  logic [2:0]        ra, ca, rb, cb;
  logic [2:0]        shift;
  logic [2:0]        ra_n, ca_n, rb_n, cb_n;
  logic [4:0]        idx_a, idx_b;

  function automatic logic [2:0] add_mod5(input logic [2:0] v, input logic [2:0] s);
    logic [3:0] sum;
    sum = {1'b0, v} + {1'b0, s};
    return (sum >= 4'd5) ? 3'(sum - 4'd5) : sum[2:0];
  endfunction

  assign out_free = !digraphs.valid || digraphs.ready;
  assign s1_load  = !s1_valid || out_free;
  assign pop      = head.valid && s1_load;

  // Compare both letters against every cell.
  always_comb begin
    for (int i = 0; i < pfc_pkg::CELLS; i++) begin
      match_a[i] = (square[i] == head.pair.a);
      match_b[i] = (square[i] == head.pair.b);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= head.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_match_a <= match_a;
      s1_match_b <= match_b;
      s1_last    <= head.pair.last;
    end
  end

  // Lowest matching cell wins; no match locates at cell zero.
  always_comb begin
    ra = '0;
    ca = '0;
    rb = '0;
    cb = '0;
    for (int i = pfc_pkg::CELLS - 1; i >= 0; i--) begin
      if (s1_match_a[i]) begin
        ra = 3'(i / pfc_pkg::SIDE);
        ca = 3'(i % pfc_pkg::SIDE);
      end
      if (s1_match_b[i]) begin
        rb = 3'(i / pfc_pkg::SIDE);
        cb = 3'(i % pfc_pkg::SIDE);
      end
    end
  end

  always_comb begin
    shift = decrypt_mode ? pfc_pkg::SHIFT_DEC : pfc_pkg::SHIFT_ENC;
    ra_n  = ra;
    ca_n  = ca;
    rb_n  = rb;
    cb_n  = cb;
    if (ca == cb) begin
      ra_n = add_mod5(ra, shift);
      rb_n = add_mod5(rb, shift);
    end else if (ra == rb) begin
      ca_n = add_mod5(ca, shift);
      cb_n = add_mod5(cb, shift);
    end else begin
      ca_n = cb;
      cb_n = ca;
    end
    idx_a = {ra_n, 2'b00} + {2'b00, ra_n} + {2'b00, ca_n};
    idx_b = {rb_n, 2'b00} + {2'b00, rb_n} + {2'b00, cb_n};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digraphs.valid <= 1'b0;
    end else if (out_free) begin
      digraphs.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      digraphs.first_out  <= square[idx_a];
      digraphs.second_out <= square[idx_b];
      digraphs.final_pair <= s1_last;
    end
  end

endmodule

// File: verif/pfc_digraph_checker.sv
module pfc_digraph_checker
  import pfc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  pfc_letter_if                 letters,
  pfc_digraph_if                digraphs,
  input  logic                  cfg_wr_en,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fails,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic     decrypt;
  letter_t  key_square [CELLS];
  logic     waiting_valid;
  letter_t  waiting_letter;
  digraph_t digraph_q [$];

  // Lowest cell holding the letter; a letter that is absent maps to cell 0.
  function automatic int cell_of(letter_t c);
    for (int i = 0; i < CELLS; i++) begin
      if (key_square[i] == c) return i;
    end
    return 0;
  endfunction

  function automatic digraph_t map_digraph(letter_t a, letter_t b, logic last);
    int ia, ib, ca, ra, cb, rb, sh, t;
    digraph_t d;
    sh = decrypt ? int'(SHIFT_DEC) : int'(SHIFT_ENC);
    ia = cell_of(a);
    ib = cell_of(b);
    ca = ia % SIDE;
    ra = ia / SIDE;
    cb = ib % SIDE;
    rb = ib / SIDE;
    if (ca == cb) begin
      ra = (ra + sh) % SIDE;
      rb = (rb + sh) % SIDE;
    end else if (ra == rb) begin
      ca = (ca + sh) % SIDE;
      cb = (cb + sh) % SIDE;
    end else begin
      t  = ca;
      ca = cb;
      cb = t;
    end
    d.a    = key_square[ra * SIDE + ca];
    d.b    = key_square[rb * SIDE + cb];
    d.last = last;
    return d;
  endfunction

  function automatic void take_letter(letter_t raw, logic eom);
    letter_t c;
    c = (raw == CODE_J) ? CODE_I : raw;
    if (waiting_valid) begin
      if (waiting_letter != c) begin
        digraph_q.push_back(map_digraph(waiting_letter, c, eom));
        waiting_valid = 1'b0;
        return;
      end
      // doubled letter: fill the waiting one, the new one waits unless the message ends
      digraph_q.push_back(map_digraph(waiting_letter, (c == CODE_X) ? CODE_Q : CODE_X, 1'b0));
    end
    if (eom) begin
      digraph_q.push_back(map_digraph(c, (c == CODE_Z) ? CODE_X : CODE_Z, 1'b1));
      waiting_valid  = 1'b0;
      waiting_letter = '0;
    end else begin
      waiting_valid  = 1'b1;
      waiting_letter = c;
    end
  endfunction

  function automatic void write_reg(logic [1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (cfg_reg_t'(idx))
      REG_DECRYPT_MODE: decrypt = data[0];
      REG_SQUARE_A: for (int k = 0; k < 9; k++) key_square[k] = data[5*k +: 5];
      REG_SQUARE_B: for (int k = 0; k < 8; k++) key_square[9 + k] = data[5*k +: 5];
      REG_SQUARE_C: for (int k = 0; k < 8; k++) key_square[17 + k] = data[5*k +: 5];
      default: ;
    endcase
  endfunction

  function automatic void check_word();
    digraph_t want;
    if (digraph_q.size() == 0) begin
      $error("digraph word with nothing expected: first_out %0d second_out %0d final_pair %0d",
             digraphs.first_out, digraphs.second_out, digraphs.final_pair);
      fails++;
      return;
    end
    want = digraph_q.pop_front();
    if (digraphs.first_out !== want.a) begin
      $error("first_out: expected %0d, actual %0d", want.a, digraphs.first_out);
      fails++;
    end
    if (digraphs.second_out !== want.b) begin
      $error("second_out: expected %0d, actual %0d", want.b, digraphs.second_out);
      fails++;
    end
    if (digraphs.final_pair !== want.last) begin
      $error("final_pair: expected %0d, actual %0d", want.last, digraphs.final_pair);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      decrypt = 1'b0;
      foreach (key_square[i]) key_square[i] = '0;
      waiting_valid  = 1'b0;
      waiting_letter = '0;
      digraph_q.delete();
    end else begin
      if (cfg_wr_en) write_reg(cfg_index, cfg_data);
      if (digraphs.valid && digraphs.ready) check_word();
      if (letters.valid && letters.ready) take_letter(letters.letter_in, letters.end_of_message);
    end
    pending = digraph_q.size();
  end

endmodule

// File: verif/tb_top.sv
module tb_top;
  import pfc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE      = 8;

  logic                  clk;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [1:0]            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fails;
  int                    pending_words;
  int                    cycle_count = 0;
  bit                    gaps_on;
  letter_t               key_cells [CELLS];

  pfc_letter_if  letters_ch ();
  pfc_digraph_if digraphs_ch ();

  playfair_digraph_cipher u_dut (
    .clk       (clk),
    .rst       (rst),
    .letters   (letters_ch),
    .digraphs  (digraphs_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pfc_digraph_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .letters   (letters_ch),
    .digraphs  (digraphs_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fails     (fails),
    .pending   (pending_words)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Digraph side: random stall bursts while gaps are enabled.
  initial begin
    digraphs_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
        digraphs_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      digraphs_ch.ready <= 1'b1;
    end
  end

  // All tasks below are entered and left at a falling edge.
  task automatic send_letter(letter_t c, logic eom);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      letters_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    letters_ch.valid          <= 1'b1;
    letters_ch.letter_in      <= c;
    letters_ch.end_of_message <= eom;
    do @(posedge clk); while (!letters_ch.ready);
    @(negedge clk);
  endtask

  task automatic send_text(string s, logic last_eom);
    for (int i = 0; i < s.len(); i++) begin
      send_letter(letter_t'(s[i] - "A"), last_eom && (i == s.len() - 1));
    end
  endtask

  // Hold the letter side idle until every digraph has come back.
  task automatic drain();
    letters_ch.valid <= 1'b0;
    while (pending_words != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
  endtask

  task automatic set_config(logic mode, logic [CFG_DATA_W-1:0] a,
                            logic [CFG_DATA_W-1:0] b, logic [CFG_DATA_W-1:0] c);
    write_reg(REG_DECRYPT_MODE, CFG_DATA_W'(mode));
    write_reg(REG_SQUARE_A, a);
    write_reg(REG_SQUARE_B, b);
    write_reg(REG_SQUARE_C, c);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [CFG_DATA_W-1:0] pack_cells(int first, int count);
    logic [CFG_DATA_W-1:0] r;
    r = '0;
    for (int k = 0; k < count; k++) r[5*k +: 5] = key_cells[first + k];
    return r;
  endfunction

  task automatic load_key(logic mode);
    set_config(mode, pack_cells(0, 9), pack_cells(9, 8), pack_cells(17, 8));
  endtask

  // Random permutation of the 25 letters other than J.
  function automatic void shuffle_key();
    int n, j;
    letter_t t;
    n = 0;
    for (int c = 0; c < 26; c++) begin
      if (letter_t'(c) != CODE_J) begin
        key_cells[n] = letter_t'(c);
        n++;
      end
    end
    for (int i = CELLS - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = key_cells[i];
      key_cells[i] = key_cells[j];
      key_cells[j] = t;
    end
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_bits(int width);
    logic [63:0] r;
    r = {$urandom, $urandom};
    return CFG_DATA_W'(r & ((64'd1 << width) - 64'd1));
  endfunction

  // Mostly letters of the alphabet, with doubled letters, J, the unused
  // codes above Z and message ends mixed in. Close each run with a message end.
  task automatic run_stream(int count);
    letter_t pick, prev;
    int r;
    prev = '0;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 25) pick = prev;
      else if (r < 30) pick = CODE_J;
      else if (r < 36) pick = letter_t'($urandom_range(26, 31));
      else pick = letter_t'($urandom_range(0, 25));
      send_letter(pick, (k == count - 1) || ($urandom_range(0, 7) == 0));
      prev = pick;
    end
    drain();
  endtask

  initial begin
    string std_key;
    std_key = "PLAYFIREXMBCDGHKNOQSTUVWZ";
    rst                       = 1'b1;
    gaps_on                   = 1'b1;
    letters_ch.valid          = 1'b0;
    letters_ch.letter_in      = '0;
    letters_ch.end_of_message = 1'b0;
    cfg_wr_en                 = 1'b0;
    cfg_index                 = '0;
    cfg_data                  = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < CELLS; i++) key_cells[i] = letter_t'(std_key[i] - "A");
    load_key(1'b0);

    // rectangle, row, column, row wrap, rectangle, column wrap, doubled L,
    // doubled X, then J folding into I
    send_text("HIPYADFPZYTPLLEXXJ", 1'b0);
    // doubled letter on the message end, lone Z, lone O
    send_text("JI", 1'b1);
    send_text("Z", 1'b1);
    send_text("O", 1'b1);
    // codes past Z: absent from the square, so they sit at cell 0
    send_letter(letter_t'(26), 1'b0);
    send_letter(letter_t'(31), 1'b0);
    send_letter(letter_t'(30), 1'b0);
    send_letter(letter_t'(0), 1'b1);
    drain();

    load_key(1'b1);
    run_stream(90);

    shuffle_key();
    load_key(1'b0);
    run_stream(90);

    // duplicates and codes past Z inside the square
    set_config(logic'($urandom_range(0, 1)), random_bits(45), random_bits(40),
               random_bits(40));
    run_stream(80);

    gaps_on = 1'b0;
    shuffle_key();
    load_key(1'b1);
    run_stream(60);
    gaps_on = 1'b1;

    set_config(1'b1, {45{1'b1}}, CFG_DATA_W'({40{1'b1}}), CFG_DATA_W'({40{1'b1}}));
    run_stream(30);

    set_config(1'b0, '0, '0, '0);
    run_stream(30);

    shuffle_key();
    load_key(logic'($urandom_range(0, 1)));
    gaps_on = 1'b0;
    run_stream(100);

    if (fails == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/pfc_pkg.sv
rtl/pfc_letter_if.sv
rtl/pfc_digraph_if.sv
rtl/pfc_pair.sv
rtl/pfc_cipher.sv
rtl/playfair_digraph_cipher.sv
verif/pfc_digraph_checker.sv
verif/tb_top.sv
